/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Entry layout, operation and status codes, controller states and command/status bundles.
// No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_HEAD,
    ST_SHIFT,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    take_item;
    logic    ptr_from_count;
    logic    ptr_clear;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    rd_head;
    logic    rd_below;
    logic    rd_above;
    logic    wr_shift;
    logic    wr_new;
    logic    grab_head;
    logic    set_status;
    status_e status;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    post;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              full;
    logic              move_down;
    logic              ptr_one;
    logic              shift_more;
    logic              multi;
    logic              out_busy;
  } stat_t;

endpackage

/* rtl/spq_item_if.sv */
// Request channel of the sorted priority queue: valid/ready plus one operation.
// Depends on spq_pkg.
interface spq_item_if;
  logic                       valid;
  logic                       ready;
  logic [spq_pkg::KIND_W-1:0]  kind;
  logic [spq_pkg::ID_W-1:0]    patient_id;
  logic [spq_pkg::LEVEL_W-1:0] level;

  modport source (output valid, kind, patient_id, level, input ready);
  modport sink   (input valid, kind, patient_id, level, output ready);
endinterface

/* rtl/spq_result_if.sv */
// Response channel of the sorted priority queue: valid/ready plus one result.
// Depends on spq_pkg; occupancy width follows the queue depth.
interface spq_result_if #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
);
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic                        head_valid;
  logic [spq_pkg::ID_W-1:0]     head_id;
  logic [spq_pkg::LEVEL_W-1:0]  head_level;
  logic [CNT_W-1:0]            occupancy;

  modport source (output valid, status, head_valid, head_id, head_level, occupancy,
                  input ready);
  modport sink   (input valid, status, head_valid, head_id, head_level, occupancy,
                  output ready);
endinterface

/* rtl/spq_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// Default sizes come from spq_pkg.
module spq_ram #(
  parameter int unsigned WIDTH = spq_pkg::ENTRY_W,
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/spq_datapath.sv */
// Datapath of the sorted priority queue: entry RAM, fill count, position pointer,
// captured request, result fields and the output register. Depends on spq_pkg, spq_ram.
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [spq_pkg::KIND_W-1:0]   in_kind_i,
  input  logic [spq_pkg::ID_W-1:0]     in_patient_id_i,
  input  logic [spq_pkg::LEVEL_W-1:0]  in_level_i,
  input  spq_pkg::cmd_t                cmd_i,
  output spq_pkg::stat_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [spq_pkg::STATUS_W-1:0] out_status_o,
  output logic                        out_head_valid_o,
  output logic [spq_pkg::ID_W-1:0]     out_head_id_o,
  output logic [spq_pkg::LEVEL_W-1:0]  out_head_level_o,
  output logic [CNT_W-1:0]            out_occupancy_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [spq_pkg::KIND_W-1:0] kind_q;
  spq_pkg::entry_t            item_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W:0]   ptr_plus2;

  spq_pkg::status_e status_q, status_d;
  logic             hv_q, hv_d;
  spq_pkg::entry_t  head_q, head_d;

  logic                         rd_en;
  logic [spq_pkg::ENTRY_W-1:0]  rd_word;
  spq_pkg::entry_t              rd_data;
  spq_pkg::entry_t              wr_data;

  logic                         out_valid_q, out_valid_d;
  spq_pkg::status_e             out_status_q;
  logic                         out_hv_q;
  spq_pkg::entry_t              out_head_q;
  logic [CNT_W-1:0]             out_occ_q;

  // pointer and count
  always_comb begin
    ptr_d = ptr_q;
    priority if (cmd_i.ptr_from_count) ptr_d = count_q;
    else if (cmd_i.ptr_clear)          ptr_d = '0;
    else if (cmd_i.ptr_dec)            ptr_d = ptr_q - CNT_W'(1);
    else if (cmd_i.ptr_inc)            ptr_d = ptr_q + CNT_W'(1);
    else                               ptr_d = ptr_q;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // read address is taken relative to the pointer value of the next cycle
  always_comb begin
    rd_ptr = '0;
    if (cmd_i.rd_below) begin
      rd_ptr = ptr_d - CNT_W'(1);
    end else if (cmd_i.rd_above) begin
      rd_ptr = ptr_d + CNT_W'(1);
    end
  end

  assign rd_en   = cmd_i.rd_head | cmd_i.rd_below | cmd_i.rd_above;
  assign rd_data = spq_pkg::entry_t'(rd_word);
  assign wr_data = cmd_i.wr_new ? item_q : rd_data;

  spq_ram #(
    .WIDTH(spq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_spq_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.wr_shift | cmd_i.wr_new),
    .wr_addr_i(ptr_q[ADDR_W-1:0]),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_ptr[ADDR_W-1:0]),
    .rd_data_o(rd_word)
  );

  // result fields
  always_comb begin
    status_d = status_q;
    hv_d     = hv_q;
    head_d   = head_q;
    if (cmd_i.take_item) begin
      status_d = spq_pkg::STATUS_OK;
      hv_d     = 1'b0;
      head_d   = '0;
    end
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
    if (cmd_i.grab_head) begin
      hv_d   = 1'b1;
      head_d = rd_data;
    end
  end

  assign out_valid_d = cmd_i.post | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      kind_q       <= in_kind_i;
      item_q.id    <= in_patient_id_i;
      item_q.level <= in_level_i;
    end
    status_q <= status_d;
    hv_q     <= hv_d;
    head_q   <= head_d;
    if (cmd_i.post) begin
      out_status_q <= status_q;
      out_hv_q     <= hv_q;
      out_head_q   <= head_q;
      out_occ_q    <= count_q;
    end
  end

  assign ptr_plus2 = {1'b0, ptr_q} + (CNT_W + 1)'(2);

  assign sts_o.kind       = kind_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CNT_W'(DEPTH));
  assign sts_o.move_down  = (rd_data.level > item_q.level);
  assign sts_o.ptr_one    = (ptr_q == CNT_W'(1));
  assign sts_o.shift_more = (ptr_plus2 < {1'b0, count_q});
  assign sts_o.multi      = (count_q > CNT_W'(1));
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_head_valid_o = out_hv_q;
  assign out_head_id_o    = out_head_q.id;
  assign out_head_level_o = out_head_q.level;
  assign out_occupancy_o  = out_occ_q;

endmodule

/* rtl/spq_ctrl.sv */
// Controller of the sorted priority queue: sequences insert shifts, head reads,
// remove shifts and result posting. Depends on spq_pkg.
module spq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spq_pkg::stat_t sts_i,
  output spq_pkg::cmd_t  cmd_o
);

  spq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = spq_pkg::ST_DISPATCH;
      end
      spq_pkg::ST_DISPATCH: begin
        unique case (sts_i.kind)
          spq_pkg::KIND_INSERT: begin
            if (sts_i.full)       state_d = spq_pkg::ST_DONE;
            else if (sts_i.empty) state_d = spq_pkg::ST_INS_PUT;
            else                  state_d = spq_pkg::ST_INS_CMP;
          end
          spq_pkg::KIND_REMOVE, spq_pkg::KIND_PEEK: begin
            state_d = sts_i.empty ? spq_pkg::ST_DONE : spq_pkg::ST_HEAD;
          end
          default: state_d = spq_pkg::ST_DONE;
        endcase
      end
      spq_pkg::ST_INS_CMP: begin
        if (!sts_i.move_down)   state_d = spq_pkg::ST_DONE;
        else if (sts_i.ptr_one) state_d = spq_pkg::ST_INS_PUT;
        else                    state_d = spq_pkg::ST_INS_CMP;
      end
      spq_pkg::ST_INS_PUT: state_d = spq_pkg::ST_DONE;
      spq_pkg::ST_HEAD: begin
        if (sts_i.kind == spq_pkg::KIND_REMOVE && sts_i.multi) begin
          state_d = spq_pkg::ST_SHIFT;
        end else begin
          state_d = spq_pkg::ST_DONE;
        end
      end
      spq_pkg::ST_SHIFT: begin
        state_d = sts_i.shift_more ? spq_pkg::ST_SHIFT : spq_pkg::ST_DONE;
      end
      spq_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = spq_pkg::ST_IDLE;
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = spq_pkg::STATUS_OK;
    in_ready_o   = 1'b0;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
      end
      spq_pkg::ST_DISPATCH: begin
        unique case (sts_i.kind)
          spq_pkg::KIND_INSERT: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = spq_pkg::STATUS_FULL;
            end else begin
              cmd_o.ptr_from_count = 1'b1;
              cmd_o.rd_below       = ~sts_i.empty;  // last occupied entry
            end
          end
          spq_pkg::KIND_REMOVE, spq_pkg::KIND_PEEK: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = spq_pkg::STATUS_EMPTY;
            end else begin
              cmd_o.rd_head   = 1'b1;
              cmd_o.ptr_clear = 1'b1;
            end
          end
          default: ;
        endcase
      end
      spq_pkg::ST_INS_CMP: begin
        if (sts_i.move_down) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          cmd_o.rd_below = ~sts_i.ptr_one;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      spq_pkg::ST_INS_PUT: begin
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      spq_pkg::ST_HEAD: begin
        cmd_o.grab_head = 1'b1;
        if (sts_i.kind == spq_pkg::KIND_REMOVE) begin
          if (sts_i.multi) cmd_o.rd_above = 1'b1;
          else             cmd_o.cnt_dec  = 1'b1;
        end
      end
      spq_pkg::ST_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        if (sts_i.shift_more) cmd_o.rd_above = 1'b1;
        else                  cmd_o.cnt_dec  = 1'b1;
      end
      spq_pkg::ST_DONE: begin
        cmd_o.post = ~sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue, top level: controller plus datapath.
// Depends on spq_pkg, spq_item_if, spq_result_if, spq_ctrl, spq_datapath.
//
// Usage:
//   req_i carries one operation per transaction (kind: insert, remove head,
//   peek head; patient_id and level for an insert). rsp_o returns exactly one
//   result per request: status, head_valid/head_id/head_level for a remove or
//   peek, and the occupancy after the operation.
//   Entries are kept sorted by level in a DEPTH-entry RAM; an insert lands
//   behind all entries of equal or lower level, so equal levels leave FIFO.
//
// Throughput: one request at a time, the next one is taken the cycle after the
// result is loaded into the output register. The single-port-read RAM sets the
// pace: every moved entry costs one read and one write.
// Reset: queue empty, output register empty, req_i.ready high. RAM contents
// are not cleared; only occupied entries are ever read.
// Stall: a waiting result sits in the output register; the next request can
// be taken and processed, and its result waits until rsp_o.ready frees it.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spq_item_if.sink     req_i,
  spq_result_if.source rsp_o
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t sts;

  spq_ctrl u_spq_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(req_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spq_datapath #(
    .DEPTH(DEPTH)
  ) u_spq_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_kind_i       (req_i.kind),
    .in_patient_id_i (req_i.patient_id),
    .in_level_i      (req_i.level),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_status_o    (rsp_o.status),
    .out_head_valid_o(rsp_o.head_valid),
    .out_head_id_o   (rsp_o.head_id),
    .out_head_level_o(rsp_o.head_level),
    .out_occupancy_o (rsp_o.occupancy)
  );

endmodule

/* rtl/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit.
module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [spq_pkg::STATUS_W-1:0] out_status_i,
  input logic                        out_head_valid_i,
  input logic [spq_pkg::ID_W-1:0]     out_head_id_i,
  input logic [spq_pkg::LEVEL_W-1:0]  out_head_level_i,
  input logic [CNT_W-1:0]            out_occupancy_i
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_head_id_i) && $stable(out_head_level_i)
      && $stable(out_occupancy_i) && $stable(out_head_valid_i))
    else $error("result changed while stalled");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == spq_pkg::STATUS_FULL
      |-> out_occupancy_i == CNT_W'(DEPTH) && !out_head_valid_i)
    else $error("full status with wrong occupancy or head");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == spq_pkg::STATUS_EMPTY
      |-> out_occupancy_i == '0 && !out_head_valid_i)
    else $error("empty status with wrong occupancy or head");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_occupancy_i <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .DEPTH(DEPTH)
) u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .out_status_i    (rsp_o.status),
  .out_head_valid_i(rsp_o.head_valid),
  .out_head_id_i   (rsp_o.head_id),
  .out_head_level_i(rsp_o.head_level),
  .out_occupancy_i (rsp_o.occupancy)
);

/* sim/sorted_priority_queue_unit_tb.sv */
// Testbench for sorted_priority_queue_unit: insert/remove/peek traffic with random gaps and stalls.
// Results are checked against an in-bench sorted-array model of the queue.
// Depends on spq_pkg, spq_item_if, spq_result_if and the RTL of the unit.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEF;
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  localparam int unsigned RANDOM_OPS     = 1800;
  localparam int unsigned QUIET_LIMIT    = 1000;  // cycles with no transaction on either side
  localparam int unsigned DRAIN_CYCLES   = 40;    // longer than the slowest remove of a full queue
  localparam int unsigned MAX_GAP        = 10;

  // kind code the unit leaves undefined; it must answer ok and change nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one operation on its way to the unit
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    patient_id;
    logic [LEVEL_W-1:0] level;
    logic               quick;  // no gap or stall around this transaction
  } queue_op_t;

  // what the unit must answer for one operation
  typedef struct {
    status_e            status;
    logic               head_valid;
    logic [ID_W-1:0]    head_id;
    logic [LEVEL_W-1:0] head_level;
    logic [CNT_W-1:0]   occupancy;
    logic               quick;
  } queue_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side, driven at the rising edge
  logic               req_valid = 1'b0;
  logic [KIND_W-1:0]  req_kind = KIND_INSERT;
  logic [ID_W-1:0]    req_id = '0;
  logic [LEVEL_W-1:0] req_level = '0;
  // response side
  logic               rsp_ready = 1'b1;

  spq_item_if                      req_if ();
  spq_result_if #(.DEPTH(DEPTH))   rsp_if ();

  assign req_if.valid      = req_valid;
  assign req_if.kind       = req_kind;
  assign req_if.patient_id = req_id;
  assign req_if.level      = req_level;
  assign rsp_if.ready      = rsp_ready;

  sorted_priority_queue_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow queue: sorted by level, equal levels in arrival order.
  // ---------------------------------------------------------------------------
  entry_t         sorted_entries [DEPTH];
  int unsigned    entry_total = 0;

  queue_op_t      ops_to_send [$];
  queue_outcome_t outcomes_due [$];
  int unsigned    mismatches = 0;

  function automatic queue_outcome_t queue_op_outcome(queue_op_t op);
    queue_outcome_t res;
    int unsigned    pos;
    res.status     = STATUS_OK;
    res.head_valid = 1'b0;
    res.head_id    = '0;
    res.head_level = '0;
    res.quick      = op.quick;
    case (op.kind)
      KIND_INSERT: begin
        if (entry_total >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          // walk up from the tail past every entry of strictly higher level
          pos = entry_total;
          while (pos > 0 && sorted_entries[pos-1].level > op.level) begin
            sorted_entries[pos] = sorted_entries[pos-1];
            pos--;
          end
          sorted_entries[pos].id    = op.patient_id;
          sorted_entries[pos].level = op.level;
          entry_total++;
        end
      end
      KIND_REMOVE, KIND_PEEK: begin
        if (entry_total == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.head_valid = 1'b1;
          res.head_id    = sorted_entries[0].id;
          res.head_level = sorted_entries[0].level;
          if (op.kind == KIND_REMOVE) begin
            // only occupied slots move toward the head
            for (int k = 0; k + 1 < entry_total; k++) begin
              sorted_entries[k] = sorted_entries[k+1];
            end
            entry_total--;
          end
        end
      end
      default: ;  // unused kind: nothing changes
    endcase
    res.occupancy = CNT_W'(entry_total);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents queued operations, waits a drawn gap after each.
  // The outcome is computed at the edge that accepts the transaction.
  // ---------------------------------------------------------------------------
  queue_op_t   op_on_bus;
  int unsigned send_gap = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && req_if.ready) begin
        outcomes_due.push_back(queue_op_outcome(op_on_bus));
      end
      if (!req_valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          op_on_bus = ops_to_send.pop_front();
          req_valid <= 1'b1;
          req_kind  <= op_on_bus.kind;
          req_id    <= op_on_bus.patient_id;
          req_level <= op_on_bus.level;
          send_gap = op_on_bus.quick ? 0 : $urandom_range(MAX_GAP, 0);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: compares each result with the oldest outcome due, then
  // holds ready low for a drawn number of cycles while a result is waiting.
  // ---------------------------------------------------------------------------
  queue_outcome_t due;
  int unsigned    recv_stall = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready <= 1'b1;
      recv_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        if (outcomes_due.size() == 0) begin
          $error("result with no operation outstanding: status %0d occupancy %0d",
                 rsp_if.status, rsp_if.occupancy);
          mismatches++;
        end else begin
          due = outcomes_due.pop_front();
          if (rsp_if.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_if.status);
            mismatches++;
          end
          if (rsp_if.head_valid !== due.head_valid) begin
            $error("head_valid: expected %0d, got %0d", due.head_valid, rsp_if.head_valid);
            mismatches++;
          end
          if (rsp_if.head_id !== due.head_id) begin
            $error("head_id: expected %h, got %h", due.head_id, rsp_if.head_id);
            mismatches++;
          end
          if (rsp_if.head_level !== due.head_level) begin
            $error("head_level: expected %0d, got %0d", due.head_level, rsp_if.head_level);
            mismatches++;
          end
          if (rsp_if.occupancy !== due.occupancy) begin
            $error("occupancy: expected %0d, got %0d", due.occupancy, rsp_if.occupancy);
            mismatches++;
          end
          recv_stall = due.quick ? 0 : $urandom_range(MAX_GAP, 0);
        end
      end else if (rsp_if.valid && recv_stall > 0) begin
        recv_stall--;
      end
      rsp_ready <= (recv_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a hung handshake on either side ends the run.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic quick_mode = 1'b0;

  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] pid,
                        input logic [LEVEL_W-1:0] lvl);
    queue_op_t op;
    op.kind       = kind;
    op.patient_id = pid;
    op.level      = lvl;
    op.quick      = quick_mode;
    ops_to_send.push_back(op);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || req_valid || outcomes_due.size() != 0);
  endtask

  initial begin
    int unsigned      random_sent;
    int unsigned      chunk_len;
    int unsigned      bias;
    int unsigned      level_mode;
    int unsigned      pick;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    pid;
    logic [LEVEL_W-1:0] lvl;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, ordering of equal levels, head insert, full queue.
    add_op(KIND_PEEK,   16'h0000, 4'd0);   // peek on empty
    add_op(KIND_REMOVE, 16'hFFFF, 4'd15);  // remove on empty
    add_op(KIND_UNUSED, 16'hFFFF, 4'd15);  // undefined kind, empty queue
    add_op(KIND_INSERT, 16'h0000, 4'd15);
    add_op(KIND_INSERT, 16'hFFFF, 4'd0);   // lands at the head
    add_op(KIND_INSERT, 16'h1234, 4'd15);  // behind the other level 15
    add_op(KIND_INSERT, 16'h00FF, 4'd7);
    add_op(KIND_PEEK,   16'h0000, 4'd0);
    add_op(KIND_REMOVE, 16'h0000, 4'd0);
    for (int i = 0; i < 13; i++) begin
      add_op(KIND_INSERT, (i % 2) ? 16'h5555 : 16'hAAAA ^ ID_W'(i),
             (i % 3 == 0) ? 4'd0 : ((i % 3 == 1) ? 4'd15 : 4'd8));
    end
    add_op(KIND_INSERT, 16'hBEEF, 4'd3);   // rejected, queue full
    add_op(KIND_UNUSED, 16'h0000, 4'd0);   // undefined kind, full queue
    add_op(KIND_PEEK,   16'h0000, 4'd0);
    wait_for_quiet();

    // Random: chunks biased toward filling, draining or mixing, so the queue
    // swings between empty and full. Levels are drawn wide, narrow (many ties)
    // or from the two extremes.
    random_sent = 0;
    while (random_sent < RANDOM_OPS) begin
      chunk_len  = $urandom_range(60, 10);
      bias       = $urandom_range(2, 0);
      level_mode = $urandom_range(2, 0);
      quick_mode = ($urandom_range(3, 0) == 0);
      lvl        = LEVEL_W'($urandom_range(14, 0));   // base for the narrow mode
      repeat (chunk_len) begin
        pick = $urandom_range(99, 0);
        case (bias)
          0:       kind = (pick < 75) ? KIND_INSERT : (pick < 88) ? KIND_REMOVE :
                          (pick < 98) ? KIND_PEEK : KIND_UNUSED;
          1:       kind = (pick < 20) ? KIND_INSERT : (pick < 75) ? KIND_REMOVE :
                          (pick < 98) ? KIND_PEEK : KIND_UNUSED;
          default: kind = (pick < 45) ? KIND_INSERT : (pick < 80) ? KIND_REMOVE :
                          (pick < 98) ? KIND_PEEK : KIND_UNUSED;
        endcase
        pick = $urandom_range(19, 0);
        pid  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
               ID_W'($urandom_range(16'hFFFF, 0));
        case (level_mode)
          0:       add_op(kind, pid, LEVEL_W'($urandom_range(15, 0)));
          1:       add_op(kind, pid, lvl + LEVEL_W'($urandom_range(1, 0)));
          default: add_op(kind, pid, $urandom_range(1, 0) ? 4'd15 : 4'd0);
        endcase
        if (kind != KIND_UNUSED) random_sent++;
      end
      if ($urandom_range(5, 0) == 0) wait_for_quiet();
    end

    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
